@@ rtl/core/trm_pkg.sv @@
`timescale 1ns / 1ps

package trm_pkg;

    // Field widths fixed by the item format.
    localparam int RATE_W = 16;
    localparam int TPM_W  = 16;
    localparam int TS_W   = 32;

    // Parameter defaults.
    localparam int WINDOW_DEPTH_DEF = 4;
    localparam int TIME_BITS_DEF    = 32;

    // Rate saturation value and register reset value.
    localparam logic [RATE_W-1:0] RATE_MAX  = 16'hFFFF;
    localparam logic [TPM_W-1:0]  TPM_RESET = 16'd60000;

    // Input operation codes.
    localparam logic OP_TAP   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Configuration port geometry and register word indexes.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_TICKS_PER_MINUTE = '0;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATE,
        ST_STORE,
        ST_SUM,
        ST_MEAN,
        ST_OUT
    } trm_state_t;

endpackage

@@ rtl/core/trm_div.sv @@
`timescale 1ns / 1ps

module trm_div #(
    parameter int DVD_W = 18,
    parameter int DVS_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   rem_shift;
    logic [DVS_W:0]   rem_diff;
    logic             take_sub;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DVD_W-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        take_sub  = (rem_shift >= {1'b0, dvs_reg});
    end

    // Step counter; done pulses for one cycle after the last quotient bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // The dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], take_sub};
            rem_reg <= take_sub ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/tap_rate_meter_moving_average_core.sv @@
`timescale 1ns / 1ps

// Channel   Signals                                       Direction
// -------   -------------------------------------------   ---------
// in        in_valid, in_ready, op, timestamp              sink
// out       out_valid, out_ready, average_rate,            source
//           latest_rate, window_fill
// apb       psel, penable, pwrite, paddr, pwdata,          slave
//           prdata, pready
//
// A tap transaction with a nonzero interval makes two passes through the shared
// bit-serial divider (one bit per cycle), the rate division and the window mean,
// and a summing pass over the ring, one entry per cycle.
// A clear transaction or a first tap skips the rate division.
// Reset clears the control state and sets ticks_per_minute to 60000.
// One input transaction is worked on at a time; the next one is taken while the
// previous result still waits in the output register, and a stalled output only
// holds the sequencer at its final step.

module tap_rate_meter_moving_average_core
#(
    parameter int WINDOW_DEPTH = trm_pkg::WINDOW_DEPTH_DEF,
    parameter int TIME_BITS    = trm_pkg::TIME_BITS_DEF,
    parameter int FILL_W       = $clog2(WINDOW_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [trm_pkg::TS_W-1:0]       timestamp,
    // Output channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [trm_pkg::RATE_W-1:0]     average_rate,
    output logic [trm_pkg::RATE_W-1:0]     latest_rate,
    output logic [FILL_W-1:0]              window_fill,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [trm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [trm_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);

    import trm_pkg::*;

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W = RATE_W + $clog2(WINDOW_DEPTH);
    localparam int DVD_W = SUM_W;
    localparam int DVS_W = TIME_BITS;

    trm_state_t            state_reg;
    trm_state_t            state_next;

    logic [TPM_W-1:0]      tpm_reg;
    logic                  awaiting_first_reg;
    logic [TIME_BITS-1:0]  prev_ts_reg;
    logic [RATE_W-1:0]     ring_mem [WINDOW_DEPTH];
    logic [IDX_W-1:0]      wr_idx_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [RATE_W-1:0]     last_rate_reg;
    logic [RATE_W-1:0]     rate_reg;
    logic [RATE_W-1:0]     mean_reg;
    logic [FILL_W-1:0]     sum_idx_reg;
    logic [SUM_W-1:0]      acc_reg;

    logic                  out_valid_reg;
    logic [RATE_W-1:0]     average_rate_reg;
    logic [RATE_W-1:0]     latest_rate_reg;
    logic [FILL_W-1:0]     window_fill_reg;

    logic                  in_fire;
    logic                  out_load;
    logic [TIME_BITS-1:0]  interval;
    logic                  interval_zero;
    logic                  div_start;
    logic [DVD_W-1:0]      div_dividend;
    logic [DVS_W-1:0]      div_divisor;
    logic                  div_done;
    logic [DVD_W-1:0]      div_quotient;
    logic                  cfg_write;
    logic [APB_ADDR_W-3:0] cfg_word;

    // Interval since the previous tap, modulo the timestamp range.
    assign interval      = timestamp[TIME_BITS-1:0] - prev_ts_reg;
    assign interval_zero = (interval == '0);
    assign in_fire       = in_valid && in_ready;

    // Configuration register access.
    assign pready    = 1'b1;
    assign cfg_word  = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (cfg_word == REG_TICKS_PER_MINUTE)
        begin
            prdata = APB_DATA_W'(tpm_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpm_reg <= TPM_RESET;
        end
        else if (cfg_write && (cfg_word == REG_TICKS_PER_MINUTE))
        begin
            tpm_reg <= pwdata[TPM_W-1:0];
        end
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_CLEAR || awaiting_first_reg)
                    begin
                        state_next = ST_SUM;
                    end
                    else if (interval_zero)
                    begin
                        state_next = ST_STORE;
                    end
                    else
                    begin
                        state_next = ST_RATE;
                    end
                end
            end
            ST_RATE:
            begin
                if (div_done)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (fill_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else if (sum_idx_reg == fill_reg)
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer and divider operand selection.
    always_comb
    begin
        in_ready     = 1'b0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        div_dividend = DVD_W'(tpm_reg);
        div_divisor  = DVS_W'(interval);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                div_start = in_valid && (op == OP_TAP) && !awaiting_first_reg
                            && !interval_zero;
            end
            ST_SUM:
            begin
                div_dividend = acc_reg;
                div_divisor  = DVS_W'(fill_reg);
                div_start    = (fill_reg != '0) && (sum_idx_reg == fill_reg);
            end
            ST_OUT:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Shared bit-serial divider: rate first, then the window mean.
    trm_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Measurement state: first-tap flag, previous timestamp, ring pointers, last rate.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_first_reg <= 1'b1;
            prev_ts_reg        <= '0;
            wr_idx_reg         <= '0;
            fill_reg           <= '0;
            last_rate_reg      <= '0;
        end
        else if (in_fire)
        begin
            if (op == OP_CLEAR)
            begin
                awaiting_first_reg <= 1'b1;
                wr_idx_reg         <= '0;
                fill_reg           <= '0;
                last_rate_reg      <= '0;
            end
            else
            begin
                awaiting_first_reg <= 1'b0;
                prev_ts_reg        <= timestamp[TIME_BITS-1:0];
            end
        end
        else if (state_reg == ST_STORE)
        begin
            last_rate_reg <= rate_reg;
            if (wr_idx_reg == IDX_W'(WINDOW_DEPTH - 1))
            begin
                wr_idx_reg <= '0;
            end
            else
            begin
                wr_idx_reg <= wr_idx_reg + 1'b1;
            end
            if (fill_reg < FILL_W'(WINDOW_DEPTH))
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // Datapath: rate capture, ring write, serial summation and the mean.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rate_reg    <= RATE_MAX;
            sum_idx_reg <= '0;
            acc_reg     <= '0;
        end
        if (state_reg == ST_RATE && div_done)
        begin
            rate_reg <= div_quotient[RATE_W-1:0];
        end
        if (state_reg == ST_STORE)
        begin
            ring_mem[wr_idx_reg] <= rate_reg;
        end
        if (state_reg == ST_SUM)
        begin
            if (fill_reg == '0)
            begin
                mean_reg <= '0;
            end
            else if (sum_idx_reg != fill_reg)
            begin
                acc_reg     <= acc_reg + SUM_W'(ring_mem[sum_idx_reg[IDX_W-1:0]]);
                sum_idx_reg <= sum_idx_reg + 1'b1;
            end
        end
        if (state_reg == ST_MEAN && div_done)
        begin
            mean_reg <= div_quotient[RATE_W-1:0];
        end
    end

    // Output register; it frees the sequencer to take the next transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            average_rate_reg <= mean_reg;
            latest_rate_reg  <= last_rate_reg;
            window_fill_reg  <= fill_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign average_rate = average_rate_reg;
    assign latest_rate  = latest_rate_reg;
    assign window_fill  = window_fill_reg;

endmodule
